// ===== src/asrb_pkg.sv =====
package asrb_pkg;

  // Fixed-point format of every Q16.16 quantity.
  localparam int FRAC_W     = 16;
  localparam int DATA_W     = 32;
  localparam int TICK_W     = 16;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 8;

  // Serial multiplier geometry: signed multiplicand, unsigned multiplier.
  localparam int MCAND_W    = DATA_W + 2;
  localparam int MPLIER_W   = GAIN_W;
  localparam int HI_W       = MCAND_W + 1;
  localparam int PROD_W     = HI_W + MPLIER_W;
  localparam int RND_W      = PROD_W - FRAC_W;
  localparam int SUM_W      = RND_W + 1;

  localparam logic [GAIN_W-1:0]    GAIN_ONE       = GAIN_W'(65536);
  localparam logic [TICK_W-1:0]    STEP_TIME_RST  = TICK_W'(655);
  localparam logic [TICK_W-1:0]    TICKS_MAX      = '1;
  localparam logic signed [DATA_W:0] SPEED_DEADBAND = (DATA_W+1)'(655);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LAG_GAIN       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FWD_UP   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FWD_DOWN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_REV_UP   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_REV_DOWN = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW       = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH      = CFG_IDX_W'(7);

  typedef struct packed {
    logic signed [DATA_W-1:0] speed_reference;
    logic                     forward_end_stop;
    logic                     reverse_end_stop;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered_accel;
    logic signed [DATA_W-1:0] axis_speed;
    logic signed [DATA_W-1:0] axis_position;
    logic                     brake_released;
    logic [TICK_W-1:0]        brake_open_ticks;
  } out_beat_t;

  // Request to and response from the serial multiplier.
  typedef struct packed {
    logic                      start;
    logic signed [MCAND_W-1:0] mcand;
    logic [MPLIER_W-1:0]       mplier;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [RND_W-1:0] prod_rnd;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LAG_GO,
    ST_LAG_WAIT,
    ST_SPD_GO,
    ST_SPD_WAIT,
    ST_POS_GO,
    ST_POS_WAIT,
    ST_DONE
  } asrb_state_t;

  // Clamp a widened sum to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] max_v;
    logic signed [SUM_W-1:0] min_v;
    max_v = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    min_v = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > max_v) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < min_v) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== src/asrb_mul.sv =====
module asrb_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  asrb_pkg::mul_req_t req,
  output asrb_pkg::mul_rsp_t rsp
);
  import asrb_pkg::*;

  localparam int CNT_W = $clog2(MPLIER_W);

  logic                      busy_r;
  logic                      fin_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [MCAND_W-1:0] mcand_r;
  logic signed [HI_W-1:0]    hi_r;
  logic [MPLIER_W-1:0]       lo_r;
  logic signed [RND_W-1:0]   res_r;

  logic signed [HI_W:0]      partial;
  logic signed [PROD_W-1:0]  prod_biased;

  // One multiplier bit per cycle: add the multiplicand if the bit is set, then shift right.
  always_comb begin
    partial = {hi_r[HI_W-1], hi_r};
    if (lo_r[0]) begin
      partial = partial + {{(HI_W+1-MCAND_W){mcand_r[MCAND_W-1]}}, mcand_r};
    end
  end

  // Round to nearest, ties upward, before dropping the fraction bits.
  assign prod_biased = $signed({hi_r, lo_r}) + $signed(PROD_W'(1) <<< (FRAC_W-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r <= req.mcand;
      hi_r    <= '0;
      lo_r    <= req.mplier;
      cnt_r   <= CNT_W'(MPLIER_W-1);
    end else if (busy_r) begin
      hi_r  <= partial[HI_W:1];
      lo_r  <= {partial[0], lo_r[MPLIER_W-1:1]};
      cnt_r <= cnt_r - 1'b1;
    end
    if (fin_r) begin
      res_r <= prod_biased[PROD_W-1:FRAC_W];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.prod_rnd = res_r;

endmodule

// ===== src/axis_speed_ramp_with_brake.sv =====
// Speed ramp for one crane axis with a holding brake. Each input beat is one
// control tick and yields exactly one result beat with the lagged acceleration,
// the speed, the position, the brake state and the brake-open tick count.
// No new beat is accepted until the previous tick has been loaded into the
// output register. The three Q16.16 products (lag filter, speed and position
// integration) run one after the other through a single bit-serial shift-add
// multiplier. Each product has a start step, one shift-add step per multiplier
// bit, a rounding step and a step to hand the result over. Accepting the beat,
// the brake decision and loading the result are steps of their own. A finished
// result waits in an output register, so the next tick is accepted while the
// previous result is still held; a tick that finishes while the previous result
// is still held waits until that result is taken. Configuration writes are
// never stalled and are meant to be made only while no tick is in flight.
module axis_speed_ramp_with_brake (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  asrb_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output asrb_pkg::out_beat_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [asrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asrb_pkg::DATA_W-1:0]      cfg_data
);
  import asrb_pkg::*;

  // Configuration registers.
  logic [TICK_W-1:0]        step_time_r;
  logic [GAIN_W-1:0]        lag_gain_r;
  logic signed [DATA_W-1:0] acc_fwd_up_r;
  logic signed [DATA_W-1:0] acc_fwd_down_r;
  logic signed [DATA_W-1:0] acc_rev_up_r;
  logic signed [DATA_W-1:0] acc_rev_down_r;
  logic signed [DATA_W-1:0] band_low_r;
  logic signed [DATA_W-1:0] band_high_r;

  // Axis state and the latched tick.
  asrb_state_t              state_r;
  asrb_state_t              state_nxt;
  logic                     brake_r;
  logic [TICK_W-1:0]        ticks_r;
  logic signed [DATA_W-1:0] lag_r;
  logic signed [DATA_W-1:0] speed_r;
  logic signed [DATA_W-1:0] pos_r;
  logic signed [DATA_W-1:0] ref_r;
  logic                     fwd_r;
  logic                     rev_r;
  logic signed [DATA_W-1:0] step_r;

  logic                     out_valid_r;
  out_beat_t                out_data_r;

  mul_req_t                 mul_req;
  mul_rsp_t                 mul_rsp;

  logic                     in_fire;
  logic                     out_free;
  logic                     brake_nxt;
  logic signed [DATA_W:0]   speed_err;
  logic signed [DATA_W-1:0] step_nxt;
  logic [GAIN_W-1:0]        gain_eff;
  logic signed [DATA_W-1:0] lag_sum;
  logic signed [DATA_W-1:0] speed_sum;
  logic signed [DATA_W-1:0] pos_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  asrb_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r    <= STEP_TIME_RST;
      lag_gain_r     <= GAIN_ONE;
      acc_fwd_up_r   <= '0;
      acc_fwd_down_r <= '0;
      acc_rev_up_r   <= '0;
      acc_rev_down_r <= '0;
      band_low_r     <= '0;
      band_high_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_TIME:      step_time_r    <= cfg_data[TICK_W-1:0];
        REG_LAG_GAIN:       lag_gain_r     <= cfg_data[GAIN_W-1:0];
        REG_ACCEL_FWD_UP:   acc_fwd_up_r   <= cfg_data;
        REG_ACCEL_FWD_DOWN: acc_fwd_down_r <= cfg_data;
        REG_ACCEL_REV_UP:   acc_rev_up_r   <= cfg_data;
        REG_ACCEL_REV_DOWN: acc_rev_down_r <= cfg_data;
        REG_BAND_LOW:       band_low_r     <= cfg_data;
        REG_BAND_HIGH:      band_high_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Brake decision and acceleration step, both from the previous speed.
  always_comb begin
    if (ref_r != '0) begin
      brake_nxt = 1'b1;
    end else if (speed_r > band_low_r && speed_r < band_high_r) begin
      brake_nxt = 1'b0;
    end else begin
      brake_nxt = brake_r;
    end
    speed_err = {ref_r[DATA_W-1], ref_r} - {speed_r[DATA_W-1], speed_r};
    step_nxt  = '0;
    if (speed_err > SPEED_DEADBAND) begin
      step_nxt = (ref_r > 0) ? acc_fwd_up_r : acc_rev_down_r;
    end else if (speed_err < -SPEED_DEADBAND) begin
      step_nxt = (ref_r > 0) ? acc_fwd_down_r : acc_rev_up_r;
    end
    if ((step_nxt > 0 && fwd_r) || (step_nxt < 0 && rev_r)) begin
      step_nxt = '0;
    end
  end

  assign gain_eff = (lag_gain_r > GAIN_ONE) ? GAIN_ONE : lag_gain_r;

  // Saturating updates from the rounded product.
  assign lag_sum   = sat32({{(SUM_W-DATA_W){lag_r[DATA_W-1]}}, lag_r}
                           + {mul_rsp.prod_rnd[RND_W-1], mul_rsp.prod_rnd});
  assign speed_sum = sat32({{(SUM_W-DATA_W){speed_r[DATA_W-1]}}, speed_r}
                           + {mul_rsp.prod_rnd[RND_W-1], mul_rsp.prod_rnd});
  assign pos_sum   = sat32({{(SUM_W-DATA_W){pos_r[DATA_W-1]}}, pos_r}
                           + {mul_rsp.prod_rnd[RND_W-1], mul_rsp.prod_rnd});

  // Next-state logic of the tick sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = ST_PREP;
      ST_PREP:     state_nxt = ST_LAG_GO;
      ST_LAG_GO:   state_nxt = ST_LAG_WAIT;
      ST_LAG_WAIT: if (mul_rsp.done) state_nxt = ST_SPD_GO;
      ST_SPD_GO:   state_nxt = ST_SPD_WAIT;
      ST_SPD_WAIT: if (mul_rsp.done) state_nxt = ST_POS_GO;
      ST_POS_GO:   state_nxt = ST_POS_WAIT;
      ST_POS_WAIT: if (mul_rsp.done) state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operands for each product.
  always_comb begin
    mul_req = '0;
    case (state_r)
      ST_LAG_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{(MCAND_W-DATA_W){step_r[DATA_W-1]}}, step_r}
                         - {{(MCAND_W-DATA_W){lag_r[DATA_W-1]}}, lag_r};
        mul_req.mplier = gain_eff;
      end
      ST_SPD_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{(MCAND_W-DATA_W){lag_r[DATA_W-1]}}, lag_r};
        mul_req.mplier = {{(MPLIER_W-TICK_W){1'b0}}, step_time_r};
      end
      ST_POS_GO: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{(MCAND_W-DATA_W){speed_r[DATA_W-1]}}, speed_r};
        mul_req.mplier = {{(MPLIER_W-TICK_W){1'b0}}, step_time_r};
      end
      default: mul_req = '0;
    endcase
  end

  // Sequencer state and axis state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      brake_r <= 1'b0;
      ticks_r <= '0;
      lag_r   <= '0;
      speed_r <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_PREP: begin
          brake_r <= brake_nxt;
          if (!brake_nxt) begin
            ticks_r <= '0;
          end else if (ticks_r != TICKS_MAX) begin
            ticks_r <= ticks_r + 1'b1;
          end
        end
        ST_LAG_WAIT: begin
          if (mul_rsp.done) begin
            lag_r <= brake_r ? lag_sum : '0;
          end
        end
        ST_SPD_WAIT: begin
          if (mul_rsp.done) begin
            if (!brake_r || (speed_sum > 0 && fwd_r) || (speed_sum < 0 && rev_r)) begin
              speed_r <= '0;
            end else begin
              speed_r <= speed_sum;
            end
          end
        end
        ST_POS_WAIT: begin
          if (mul_rsp.done) begin
            pos_r <= pos_sum;
          end
        end
        default: ;
      endcase
    end
  end

  // Tick capture and the chosen step.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ref_r <= in_data.speed_reference;
      fwd_r <= in_data.forward_end_stop;
      rev_r <= in_data.reverse_end_stop;
    end
    if (state_r == ST_PREP) begin
      step_r <= step_nxt;
    end
  end

  // Output register holding one result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r.filtered_accel   <= lag_r;
      out_data_r.axis_speed       <= speed_r;
      out_data_r.axis_position    <= pos_r;
      out_data_r.brake_released   <= brake_r;
      out_data_r.brake_open_ticks <= ticks_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/asrb_checker.sv =====
module asrb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input asrb_pkg::out_beat_t            out_data
);
  import asrb_pkg::*;

  // A result beat that is not taken holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One tick at a time: after a beat is taken the input is closed.
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A closed brake shows no motion and no open time.
  a_brake_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.brake_released |->
      out_data.brake_open_ticks == '0 && out_data.axis_speed == '0 &&
      out_data.filtered_accel == '0)
    else $error("motion reported with brake closed");

  // An open brake has counted at least its opening tick.
  a_brake_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brake_released |-> out_data.brake_open_ticks != '0)
    else $error("open brake with zero tick count");

endmodule

bind axis_speed_ramp_with_brake asrb_checker u_asrb_checker (.*);

// ===== verif/axis_ramp_checker.sv =====
module axis_ramp_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  asrb_pkg::in_beat_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  asrb_pkg::out_beat_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [asrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asrb_pkg::DATA_W-1:0]    cfg_data,
  output int                             mismatch_count,
  output int                             ticks_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import asrb_pkg::*;

  localparam longint AXIS_DEADBAND = 64'sd655;
  localparam longint Q_MAX         = 64'sd2147483647;
  localparam longint Q_MIN         = -64'sd2147483648;
  localparam longint UNITY_GAIN    = 64'sd65536;
  localparam int     REPORT_LIMIT  = 10;

  // Shadow copy of the register file.
  logic [TICK_W-1:0] tick_len;
  logic [GAIN_W-1:0] lag_gain;
  longint            accel_fwd_up;
  longint            accel_fwd_down;
  longint            accel_rev_up;
  longint            accel_rev_down;
  longint            band_low;
  longint            band_high;

  // Predicted axis state.
  logic              brake_open;
  longint            lag_accel;
  longint            speed;
  longint            position;
  logic [TICK_W-1:0] open_ticks;

  out_beat_t         results_due [$];
  int                errors = 0;

  function automatic longint clamp32(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Drop 16 fraction bits, rounding to nearest with ties going up.
  function automatic longint q16_round(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
    case (idx)
      REG_STEP_TIME:      tick_len = val[TICK_W-1:0];
      REG_LAG_GAIN:       lag_gain = val[GAIN_W-1:0];
      REG_ACCEL_FWD_UP:   accel_fwd_up = longint'($signed(val));
      REG_ACCEL_FWD_DOWN: accel_fwd_down = longint'($signed(val));
      REG_ACCEL_REV_UP:   accel_rev_up = longint'($signed(val));
      REG_ACCEL_REV_DOWN: accel_rev_down = longint'($signed(val));
      REG_BAND_LOW:       band_low = longint'($signed(val));
      REG_BAND_HIGH:      band_high = longint'($signed(val));
      default: ;
    endcase
  endfunction

  // Advance the axis by one control tick and return the result it produces.
  function automatic out_beat_t advance_axis(input in_beat_t beat);
    longint    cmd;
    longint    err;
    longint    accel_pick;
    longint    gain;
    longint    dt;
    out_beat_t res;
    cmd = longint'($signed(beat.speed_reference));
    dt = longint'(tick_len);
    gain = longint'(lag_gain);
    if (gain > UNITY_GAIN) gain = UNITY_GAIN;
    accel_pick = 0;

    // The brake decision looks at the speed left by the previous tick.
    if (cmd != 0) begin
      brake_open = 1'b1;
    end else if (speed > band_low && speed < band_high) begin
      brake_open = 1'b0;
    end

    if (brake_open) begin
      if (open_ticks != TICKS_MAX) open_ticks = open_ticks + 1'b1;
    end else begin
      open_ticks = '0;
    end

    // Pick the acceleration outside the deadband, then apply the end stops.
    if (brake_open) begin
      err = cmd - speed;
      if (err > AXIS_DEADBAND) begin
        accel_pick = (cmd > 0) ? accel_fwd_up : accel_rev_down;
      end else if (err < -AXIS_DEADBAND) begin
        accel_pick = (cmd > 0) ? accel_fwd_down : accel_rev_up;
      end
      if (accel_pick > 0 && beat.forward_end_stop) accel_pick = 0;
      if (accel_pick < 0 && beat.reverse_end_stop) accel_pick = 0;
      lag_accel = clamp32(lag_accel + q16_round(gain * (accel_pick - lag_accel)));
    end else begin
      lag_accel = 0;
    end

    // Euler integration of speed and position.
    speed = clamp32(speed + q16_round(lag_accel * dt));
    if (!brake_open) speed = 0;
    if ((speed > 0 && beat.forward_end_stop) || (speed < 0 && beat.reverse_end_stop)) begin
      speed = 0;
    end
    position = clamp32(position + q16_round(speed * dt));

    res.filtered_accel   = lag_accel[DATA_W-1:0];
    res.axis_speed       = speed[DATA_W-1:0];
    res.axis_position    = position[DATA_W-1:0];
    res.brake_released   = brake_open;
    res.brake_open_ticks = open_ticks;
    return res;
  endfunction

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (results_due.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%0t: result beat with no tick outstanding: accel %0d speed %0d pos %0d",
                 $realtime, got.filtered_accel, got.axis_speed, got.axis_position);
      end
    end else begin
      want = results_due.pop_front();
      if (got.filtered_accel !== want.filtered_accel ||
          got.axis_speed !== want.axis_speed ||
          got.axis_position !== want.axis_position ||
          got.brake_released !== want.brake_released ||
          got.brake_open_ticks !== want.brake_open_ticks) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: result mismatch, expected accel %0d speed %0d pos %0d brake %0b ticks %0d",
                   $realtime, want.filtered_accel, want.axis_speed, want.axis_position,
                   want.brake_released, want.brake_open_ticks);
          $display("%0t:                    actual accel %0d speed %0d pos %0d brake %0b ticks %0d",
                   $realtime, got.filtered_accel, got.axis_speed, got.axis_position,
                   got.brake_released, got.brake_open_ticks);
        end
      end
    end
  endtask

  // Sample all three channels on the clock edge where their beats complete.
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_len       = STEP_TIME_RST;
      lag_gain       = GAIN_ONE;
      accel_fwd_up   = 0;
      accel_fwd_down = 0;
      accel_rev_up   = 0;
      accel_rev_down = 0;
      band_low       = 0;
      band_high      = 0;
      brake_open     = 1'b0;
      lag_accel      = 0;
      speed          = 0;
      position       = 0;
      open_ticks     = '0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) results_due.push_back(advance_axis(in_data));
    end
    mismatch_count <= errors;
    ticks_pending  <= results_due.size();
  end

endmodule

// ===== verif/tb_axis_speed_ramp_with_brake.sv =====
module tb_axis_speed_ramp_with_brake;
  timeunit 1ns;
  timeprecision 1ps;
  import asrb_pkg::*;

  localparam int IDLE_PCT     = 34;
  localparam int PHASE_COUNT  = 9;
  localparam int PHASE_TICKS  = 100;
  localparam int CALM_PHASE   = 2;
  localparam int DRAIN_PHASE  = 3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 calm = 1'b0;
  int                   mismatch_count;
  int                   ticks_pending;

  axis_speed_ramp_with_brake i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  axis_ramp_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .ticks_pending  (ticks_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Safety net in case a handshake never completes.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // The result side stalls at random except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic in_beat_t make_beat(input logic [DATA_W-1:0] cmd,
                                         input logic fwd, input logic rev);
    in_beat_t beat;
    beat.speed_reference  = cmd;
    beat.forward_end_stop = fwd;
    beat.reverse_end_stop = rev;
    return beat;
  endfunction

  function automatic logic [DATA_W-1:0] signed_mag(input int unsigned mag);
    logic [DATA_W-1:0] v;
    v = $urandom_range(mag);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  // Speed commands: zero often enough to close the brake, mostly realistic.
  function automatic logic [DATA_W-1:0] pick_reference();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 65) return signed_mag(30000);
    if (r < 90) return signed_mag(1 << 20);
    return $urandom;
  endfunction

  // Register values for each phase, fixed and extreme settings first and random ones last.
  function automatic void choose_setting(input int phase, output logic [DATA_W-1:0] regs [8]);
    regs[REG_STEP_TIME]      = 655;
    regs[REG_LAG_GAIN]       = 20000;
    regs[REG_ACCEL_FWD_UP]   = 32'h0001_0000;
    regs[REG_ACCEL_FWD_DOWN] = DATA_W'(-98304);
    regs[REG_ACCEL_REV_UP]   = DATA_W'(-65536);
    regs[REG_ACCEL_REV_DOWN] = 32'h0001_8000;
    regs[REG_BAND_LOW]       = DATA_W'(-3000);
    regs[REG_BAND_HIGH]      = 3000;
    case (phase)
      0: ;
      1: begin
        regs[REG_STEP_TIME]      = 65535;
        regs[REG_LAG_GAIN]       = DATA_W'(GAIN_ONE);
        regs[REG_ACCEL_FWD_UP]   = 32'h7FFF_FFFF;
        regs[REG_ACCEL_FWD_DOWN] = 32'h8000_0000;
        regs[REG_ACCEL_REV_UP]   = 32'h8000_0000;
        regs[REG_ACCEL_REV_DOWN] = 32'h7FFF_FFFF;
        regs[REG_BAND_LOW]       = 32'h8000_0000;
        regs[REG_BAND_HIGH]      = 32'h7FFF_FFFF;
      end
      2: begin
        regs[REG_STEP_TIME] = 6553;
        regs[REG_LAG_GAIN]  = DATA_W'(GAIN_ONE);
      end
      3: begin
        // Zero tick length freezes motion; gain far above unity is clipped.
        regs[REG_STEP_TIME] = 0;
        regs[REG_LAG_GAIN]  = DATA_W'({GAIN_W{1'b1}});
      end
      4: begin
        regs[REG_STEP_TIME] = 1;
        regs[REG_LAG_GAIN]  = 0;
      end
      5: begin
        // An inverted band keeps the brake from ever closing again.
        regs[REG_STEP_TIME] = 65535;
        regs[REG_LAG_GAIN]  = DATA_W'(GAIN_ONE + 1'b1);
        regs[REG_BAND_LOW]  = 5000;
        regs[REG_BAND_HIGH] = DATA_W'(-5000);
      end
      default: begin
        regs[REG_STEP_TIME] = ($urandom_range(1) != 0) ? $urandom_range(2000, 1)
                                                       : $urandom_range(65535, 1);
        regs[REG_LAG_GAIN] = $urandom_range((1 << GAIN_W) - 1);
        for (int i = int'(REG_ACCEL_FWD_UP); i <= int'(REG_ACCEL_REV_DOWN); i++) begin
          regs[i] = ($urandom_range(99) < 30) ? $urandom : signed_mag(1 << 18);
        end
        if ($urandom_range(99) < 25) begin
          regs[REG_BAND_LOW]  = $urandom;
          regs[REG_BAND_HIGH] = $urandom;
        end else begin
          regs[REG_BAND_LOW]  = -$urandom_range(20000);
          regs[REG_BAND_HIGH] = $urandom_range(20000);
        end
      end
    endcase
  endfunction

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_setting(input logic [DATA_W-1:0] regs [8]);
    for (int i = int'(REG_STEP_TIME); i <= int'(REG_BAND_HIGH); i++) begin
      write_reg(CFG_IDX_W'(i), regs[i]);
    end
    // A write to an unmapped index must leave every register alone.
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(REG_BAND_HIGH) + 1)),
              $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Send one tick beat, with a random pause before it outside the calm stretch.
  task automatic send_tick(input in_beat_t beat);
    int gap;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      gap = ($urandom_range(99) < 30) ? $urandom_range(80, 6) : $urandom_range(5, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every outstanding result beat has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ticks_pending != 0) @(posedge clk);
  endtask

  // Held speed commands of random length, with some short bursts of noise.
  task automatic run_random(input int count);
    int                sent;
    int                hold;
    logic              noisy;
    logic [DATA_W-1:0] cmd;
    sent = 0;
    while (sent < count) begin
      noisy = ($urandom_range(99) < 25);
      if (noisy) begin
        cmd  = $urandom;
        hold = $urandom_range(3, 1);
      end else begin
        cmd  = pick_reference();
        hold = $urandom_range(30, 2);
      end
      for (int k = 0; k < hold && sent < count; k++) begin
        if (noisy) begin
          send_tick(make_beat(cmd, 1'($urandom_range(1)), 1'($urandom_range(1))));
        end else begin
          send_tick(make_beat(cmd, $urandom_range(99) < 8, $urandom_range(99) < 8));
        end
        sent++;
      end
    end
  endtask

  initial begin
    logic [DATA_W-1:0] regs [8];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tick length and lag gain keep their reset values for the opening ticks.
    write_reg(REG_ACCEL_FWD_UP, 32'h0001_0000);
    write_reg(REG_ACCEL_FWD_DOWN, DATA_W'(-131072));
    write_reg(REG_ACCEL_REV_UP, DATA_W'(-65536));
    write_reg(REG_ACCEL_REV_DOWN, 32'h0002_0000);
    write_reg(REG_BAND_LOW, DATA_W'(-3000));
    write_reg(REG_BAND_HIGH, 3000);
    cfg_valid <= 1'b0;

    // Brake stays shut on zero, then speed errors right at the deadband edge.
    send_tick(make_beat('0, 1'b0, 1'b0));
    send_tick(make_beat('0, 1'b1, 1'b1));
    send_tick(make_beat(655, 1'b0, 1'b0));
    send_tick(make_beat(DATA_W'(-655), 1'b0, 1'b0));
    send_tick(make_beat('0, 1'b0, 1'b0));
    send_tick(make_beat(DATA_W'(-656), 1'b0, 1'b0));
    send_tick(make_beat(656, 1'b0, 1'b0));
    send_tick(make_beat('0, 1'b0, 1'b0));
    send_tick(make_beat('0, 1'b0, 1'b0));
    // Extreme commands against the end stops.
    send_tick(make_beat(32'h7FFF_FFFF, 1'b1, 1'b0));
    send_tick(make_beat(32'h7FFF_FFFF, 1'b0, 1'b0));
    send_tick(make_beat(32'h7FFF_FFFF, 1'b0, 1'b1));
    send_tick(make_beat(32'h8000_0000, 1'b0, 1'b1));
    send_tick(make_beat(32'h8000_0000, 1'b0, 1'b0));
    send_tick(make_beat(32'h8000_0000, 1'b1, 1'b1));
    send_tick(make_beat(1, 1'b0, 1'b0));
    send_tick(make_beat(DATA_W'(-1), 1'b0, 1'b0));
    send_tick(make_beat('0, 1'b0, 1'b0));
    send_tick(make_beat('0, 1'b0, 1'b0));
    send_tick(make_beat(32'h0001_0000, 1'b0, 1'b0));
    send_tick(make_beat(32'hFFFF_0000, 1'b0, 1'b0));
    send_tick(make_beat(32'h7FFF_FFFF, 1'b1, 1'b1));
    drain_results();

    // One register setting per phase, changed only while nothing is in flight.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      choose_setting(phase, regs);
      calm <= (phase == CALM_PHASE);
      load_setting(regs);
      if (phase == DRAIN_PHASE) begin
        run_random(PHASE_TICKS / 2);
        drain_results();
        run_random(PHASE_TICKS - PHASE_TICKS / 2);
      end else begin
        run_random(PHASE_TICKS);
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && ticks_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
